// File: rtl/pidaw_pkg.sv
package pidaw_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int SUM_BITS_DEF    = 32;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_IN_MIN     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_SCALE   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INT_COEF   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DER_COEF   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS       = 4'd7;

   localparam logic [23:0] IN_SCALE_RST = 24'h080000;
   localparam logic [15:0] OUT_MAX_RST  = 16'hFFFF;
   localparam logic [15:0] GAIN_RST     = 16'h0100;

   localparam int FRAC_W = 16;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 16'h8000;

   localparam logic signed [15:0] CTL_MAX = 16'sh7FFF;
   localparam logic signed [15:0] CTL_MIN = 16'sh8000;

   // derivative term and saturated inner sum widths
   localparam int DT_W        = 26;
   localparam int INNER_SAT_W = 26;

   // shared multiplier operand widths
   localparam int MA_W = INNER_SAT_W + 1;
   localparam int MB_W = 25;

   localparam int RSP_W = 32;

endpackage

// File: rtl/pidaw_mul.sv
module pidaw_mul #(
   parameter int A_W = pidaw_pkg::MA_W,
   parameter int B_W = pidaw_pkg::MB_W
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p_ff
);

   logic signed [A_W+B_W-1:0] p_in;

   always_comb begin
      p_in = p_ff;
      if (en) begin
         p_in = a * b;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// File: rtl/pid_controller_antiwindup_top.sv
// Control item: steps MPV, MSP, FSP, UPD, MIH, MIL, ISUM, INNER, MG, CLAMP, MAP, OUT.
// Mode item: steps MPV, MODE, MAP, OUT. A new item is taken only back in idle.
// One registered multiplier forms every product (MPV, MSP, UPD, MIH, MIL, MG, MAP).
// A waiting result holds only the final step; the next item is taken meanwhile.
// Synchronous active-high reset: manual mode, zero state, registers to defaults.
module pid_controller_antiwindup_top #(
   parameter int SAMPLE_BITS = pidaw_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = pidaw_pkg::SUM_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // measured, target, auto_on (low bit up), zero padded
   input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]  req_tdata,
   // kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // drive, control_fraction (low bit up)
   output logic [pidaw_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidaw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int S       = SAMPLE_BITS;
   localparam int LO      = SUM_BITS / 2;
   localparam int HI      = SUM_BITS - LO;
   localparam int MA_W    = pidaw_pkg::MA_W;
   localparam int MB_W    = pidaw_pkg::MB_W;
   localparam int P_W     = MA_W + MB_W;
   localparam int ACC_W   = HI + 17;
   localparam int IP_W    = SUM_BITS + 18;
   localparam int DT_W    = pidaw_pkg::DT_W;
   localparam int ISW     = pidaw_pkg::INNER_SAT_W;
   localparam int INNER_W = ((SUM_BITS > DT_W) ? SUM_BITS : DT_W) + 2;
   localparam int GP_W    = P_W - 8;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MPV   = 4'd1;
   localparam logic [3:0] ST_MSP   = 4'd2;
   localparam logic [3:0] ST_FSP   = 4'd3;
   localparam logic [3:0] ST_UPD   = 4'd4;
   localparam logic [3:0] ST_MIH   = 4'd5;
   localparam logic [3:0] ST_MIL   = 4'd6;
   localparam logic [3:0] ST_ISUM  = 4'd7;
   localparam logic [3:0] ST_INNER = 4'd8;
   localparam logic [3:0] ST_MG    = 4'd9;
   localparam logic [3:0] ST_CLAMP = 4'd10;
   localparam logic [3:0] ST_MODE  = 4'd11;
   localparam logic [3:0] ST_MAP   = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;

   logic         kind_ff, kind_in;
   logic         want_ff, want_in;
   logic [S-1:0] meas_ff, meas_in;
   logic [S-1:0] targ_ff, targ_in;

   logic [S-1:0]        in_min_ff, in_min_in;
   logic [23:0]         in_scale_ff, in_scale_in;
   logic [15:0]         out_min_ff, out_min_in;
   logic [15:0]         out_max_ff, out_max_in;
   logic signed [15:0]  gain_ff, gain_in;
   logic [15:0]         icoef_ff, icoef_in;
   logic [15:0]         dcoef_ff, dcoef_in;
   logic signed [15:0]  bias_ff, bias_in;

   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [15:0]                prev_pv_ff, prev_pv_in;
   logic signed [15:0]         prev_ctl_ff, prev_ctl_in;
   logic                       auto_mode_ff, auto_mode_in;

   logic [15:0]                pv_ff, pv_in;
   logic [15:0]                sp_ff, sp_in;
   logic signed [DT_W-1:0]     dterm_ff, dterm_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SUM_BITS-1:0] iterm_ff, iterm_in;
   logic signed [ISW-1:0]      inner_ff, inner_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pidaw_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    mul_en;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [P_W-1:0]   p_ff;

   logic [S:0]                 diff_m, diff_t;
   logic                       pos_m, pos_t;
   logic [15:0]                frac_p;
   logic signed [16:0]         err, dpv;
   logic                       err_pos, err_neg, hold_int;
   logic signed [SUM_BITS:0]   sum_ext;
   logic signed [IP_W-1:0]     isum;
   logic signed [INNER_W-1:0]  inner_w;
   logic signed [GP_W:0]       c_w;
   logic signed [16:0]         span;
   logic [15:0]                drive;
   logic                       req_acc, rsp_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_valid_ff & rsp_tready;

   assign diff_m  = {1'b0, meas_ff} - {1'b0, in_min_ff};
   assign diff_t  = {1'b0, targ_ff} - {1'b0, in_min_ff};
   assign pos_m   = !diff_m[S] && (|diff_m);
   assign pos_t   = !diff_t[S] && (|diff_t);
   assign frac_p  = ((|p_ff[P_W-1:32]) || (p_ff[31:16] > pidaw_pkg::FRAC_ONE)) ?
                    pidaw_pkg::FRAC_ONE : p_ff[31:16];
   assign err     = $signed({1'b0, sp_ff}) - $signed({1'b0, pv_ff});
   assign dpv     = $signed({1'b0, pv_ff}) - $signed({1'b0, prev_pv_ff});
   assign err_pos = !err[16] && (|err);
   assign err_neg = err[16];
   assign hold_int = ((prev_ctl_ff == pidaw_pkg::CTL_MAX) && err_pos) ||
                     ((prev_ctl_ff == pidaw_pkg::CTL_MIN) && err_neg);
   assign sum_ext = {sum_ff[SUM_BITS-1], sum_ff} + {{(SUM_BITS-16){err[16]}}, err};
   assign isum    = {acc_ff, {LO{1'b0}}} + {{(IP_W-LO-17){1'b0}}, p_ff[LO+16:0]};
   assign inner_w = {{(INNER_W-17){err[16]}}, err}
                  + {{(INNER_W-SUM_BITS){iterm_ff[SUM_BITS-1]}}, iterm_ff}
                  - {{(INNER_W-DT_W){dterm_ff[DT_W-1]}}, dterm_ff};
   assign c_w     = {{(GP_W-15){bias_ff[15]}}, bias_ff} + {p_ff[P_W-1], p_ff[P_W-1:8]};
   assign span    = $signed({1'b0, out_max_ff}) - $signed({1'b0, out_min_ff});

   always_comb begin
      if (prev_ctl_ff == pidaw_pkg::CTL_MIN) begin
         drive = out_min_ff;
      end else if (prev_ctl_ff == pidaw_pkg::CTL_MAX) begin
         drive = out_max_ff;
      end else begin
         drive = out_min_ff + p_ff[31:16];
      end
   end

   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MPV: begin
            mul_a = pos_m ? {{(MA_W-S-1){1'b0}}, diff_m} : '0;
            mul_b = {{(MB_W-24){1'b0}}, in_scale_ff};
         end
         ST_MSP: begin
            mul_a = pos_t ? {{(MA_W-S-1){1'b0}}, diff_t} : '0;
            mul_b = {{(MB_W-24){1'b0}}, in_scale_ff};
         end
         ST_UPD: begin
            mul_a = {{(MA_W-17){dpv[16]}}, dpv};
            mul_b = {{(MB_W-16){1'b0}}, dcoef_ff};
         end
         ST_MIH: begin
            mul_a = {{(MA_W-HI){sum_ff[SUM_BITS-1]}}, sum_ff[SUM_BITS-1:LO]};
            mul_b = {{(MB_W-16){1'b0}}, icoef_ff};
         end
         ST_MIL: begin
            mul_a = {{(MA_W-LO){1'b0}}, sum_ff[LO-1:0]};
            mul_b = {{(MB_W-16){1'b0}}, icoef_ff};
         end
         ST_MG: begin
            mul_a = {{(MA_W-ISW){inner_ff[ISW-1]}}, inner_ff};
            mul_b = {{(MB_W-16){gain_ff[15]}}, gain_ff};
         end
         ST_MAP: begin
            mul_a = {{(MA_W-16){1'b0}}, ~prev_ctl_ff[15], prev_ctl_ff[14:0]};
            mul_b = {{(MB_W-17){span[16]}}, span};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   pidaw_mul #(
      .A_W(MA_W),
      .B_W(MB_W)
   ) u_mul (
      .clock(clock),
      .en   (mul_en),
      .a    (mul_a),
      .b    (mul_b),
      .p_ff (p_ff)
   );

   always_comb begin
      in_min_in   = in_min_ff;
      in_scale_in = in_scale_ff;
      out_min_in  = out_min_ff;
      out_max_in  = out_max_ff;
      gain_in     = gain_ff;
      icoef_in    = icoef_ff;
      dcoef_in    = dcoef_ff;
      bias_in     = bias_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pidaw_pkg::REG_IN_MIN:   in_min_in   = csr_data[S-1:0];
            pidaw_pkg::REG_IN_SCALE: in_scale_in = csr_data[23:0];
            pidaw_pkg::REG_OUT_MIN:  out_min_in  = csr_data[15:0];
            pidaw_pkg::REG_OUT_MAX:  out_max_in  = csr_data[15:0];
            pidaw_pkg::REG_GAIN:     gain_in     = csr_data[15:0];
            pidaw_pkg::REG_INT_COEF: icoef_in    = csr_data[15:0];
            pidaw_pkg::REG_DER_COEF: dcoef_in    = csr_data[15:0];
            pidaw_pkg::REG_BIAS:     bias_in     = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      want_in      = want_ff;
      meas_in      = meas_ff;
      targ_in      = targ_ff;
      sum_in       = sum_ff;
      prev_pv_in   = prev_pv_ff;
      prev_ctl_in  = prev_ctl_ff;
      auto_mode_in = auto_mode_ff;
      pv_in        = pv_ff;
      sp_in        = sp_ff;
      dterm_in     = dterm_ff;
      acc_in       = acc_ff;
      iterm_in     = iterm_ff;
      inner_in     = inner_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_acc;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in  = req_tuser;
               meas_in  = req_tdata[S-1:0];
               targ_in  = req_tdata[2*S-1:S];
               want_in  = req_tdata[2*S];
               state_in = ST_MPV;
            end
         end
         ST_MPV: begin
            state_in = kind_ff ? ST_MODE : ST_MSP;
         end
         ST_MSP: begin
            pv_in    = frac_p;
            state_in = ST_FSP;
         end
         ST_FSP: begin
            sp_in    = frac_p;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!hold_int) begin
               if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
                  sum_in = {sum_ext[SUM_BITS], {(SUM_BITS-1){~sum_ext[SUM_BITS]}}};
               end else begin
                  sum_in = sum_ext[SUM_BITS-1:0];
               end
            end
            state_in = ST_MIH;
         end
         ST_MIH: begin
            dterm_in = p_ff[DT_W+7:8];
            state_in = ST_MIL;
         end
         ST_MIL: begin
            acc_in   = p_ff[ACC_W-1:0];
            state_in = ST_ISUM;
         end
         ST_ISUM: begin
            iterm_in = isum[SUM_BITS+15:16];
            state_in = ST_INNER;
         end
         ST_INNER: begin
            if (inner_w[INNER_W-1:ISW-1] == '0 ||
                inner_w[INNER_W-1:ISW-1] == '1) begin
               inner_in = inner_w[ISW-1:0];
            end else begin
               inner_in = {inner_w[INNER_W-1], {(ISW-1){~inner_w[INNER_W-1]}}};
            end
            state_in = ST_MG;
         end
         ST_MG: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (c_w[GP_W:15] == '0 || c_w[GP_W:15] == '1) begin
               prev_ctl_in = c_w[15:0];
            end else if (c_w[GP_W]) begin
               prev_ctl_in = pidaw_pkg::CTL_MIN;
            end else begin
               prev_ctl_in = pidaw_pkg::CTL_MAX;
            end
            prev_pv_in = pv_ff;
            state_in   = ST_MAP;
         end
         ST_MODE: begin
            if (want_ff && !auto_mode_ff) begin
               sum_in      = '0;
               prev_pv_in  = frac_p;
               prev_ctl_in = bias_ff;
            end
            auto_mode_in = want_ff;
            state_in     = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {prev_ctl_ff, drive};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         prev_pv_ff   <= '0;
         prev_ctl_ff  <= '0;
         auto_mode_ff <= 1'b0;
         in_min_ff    <= '0;
         in_scale_ff  <= pidaw_pkg::IN_SCALE_RST;
         out_min_ff   <= '0;
         out_max_ff   <= pidaw_pkg::OUT_MAX_RST;
         gain_ff      <= pidaw_pkg::GAIN_RST;
         icoef_ff     <= '0;
         dcoef_ff     <= '0;
         bias_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         prev_pv_ff   <= prev_pv_in;
         prev_ctl_ff  <= prev_ctl_in;
         auto_mode_ff <= auto_mode_in;
         in_min_ff    <= in_min_in;
         in_scale_ff  <= in_scale_in;
         out_min_ff   <= out_min_in;
         out_max_ff   <= out_max_in;
         gain_ff      <= gain_in;
         icoef_ff     <= icoef_in;
         dcoef_ff     <= dcoef_in;
         bias_ff      <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      want_ff     <= want_in;
      meas_ff     <= meas_in;
      targ_ff     <= targ_in;
      pv_ff       <= pv_in;
      sp_ff       <= sp_in;
      dterm_ff    <= dterm_in;
      acc_ff      <= acc_in;
      iterm_ff    <= iterm_in;
      inner_ff    <= inner_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/pidaw_checker.sv
module pidaw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [pidaw_pkg::RSP_W-1:0] rsp_tdata
);

   // after an accept the input stays closed through MPV, MSP or MODE, and FSP or MAP
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("input ready during item work");

   // a new result appears only as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("result raised outside end of sequence");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind pid_controller_antiwindup_top pidaw_checker u_pidaw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
